// ===== design/intd_pkg.sv =====
package intd_pkg;

	// One access as presented on the request channel.
	typedef struct packed {
		logic        mode;
		logic [47:0] address;
		logic [31:0] write_data;
	} req_t;

	// One result as presented on the response channel.
	typedef struct packed {
		logic        handled;
		logic [31:0] read_data;
	} rsp_t;

	// Register group that an offset inside the window selects.
	typedef enum logic [3:0] {
		REG_NONE,
		REG_CTLR,
		REG_TYPER,
		REG_IIDR,
		REG_GROUP,
		REG_SET_EN,
		REG_CLR_EN,
		REG_SET_PEND,
		REG_CLR_PEND,
		REG_PRIO,
		REG_TARGET,
		REG_CFG
	} reg_sel_t;

	// Decoded access handed from the decoder to the register file.
	typedef struct packed {
		logic        handled;
		logic        wr;
		reg_sel_t    sel;
		logic [7:0]  idx;
		logic [31:0] wdata;
	} acc_t;

	localparam logic [47:0] BASE_RESET   = 48'h0000_0800_0000;
	localparam logic [12:0] WINDOW_SIZE  = 13'h1000;

	localparam logic [11:0] OFF_CTLR     = 12'h000;
	localparam logic [11:0] OFF_TYPER    = 12'h004;
	localparam logic [11:0] OFF_IIDR     = 12'h008;
	localparam logic [11:0] OFF_GROUP    = 12'h080;
	localparam logic [11:0] OFF_SET_EN   = 12'h100;
	localparam logic [11:0] OFF_CLR_EN   = 12'h180;
	localparam logic [11:0] OFF_SET_PEND = 12'h200;
	localparam logic [11:0] OFF_CLR_PEND = 12'h280;
	localparam logic [11:0] OFF_PRIO     = 12'h400;
	localparam logic [11:0] OFF_TARGET   = 12'h800;
	localparam logic [11:0] OFF_CFG      = 12'hC00;

	localparam logic [31:0] IIDR_VALUE   = 32'h0000_043B;
	localparam logic [31:0] GROUP_RESET  = 32'hFFFF_FFFF;
	localparam logic [31:0] PRIO_RESET   = 32'hA0A0_A0A0;
	localparam logic [31:0] TARGET_RESET = 32'h0101_0101;
	localparam logic [31:0] TARGET_LOW   = 32'h0101_0101;

	// Target words below this index cover the private interrupts.
	localparam logic [7:0]  TARGET_LOW_WORDS = 8'd8;

endpackage

// ===== design/intd_decode.sv =====
module intd_decode import intd_pkg::*; #(
	parameter int NUM_IRQS = 96
) (
	input  req_t        req,
	input  logic [47:0] window_base,
	output acc_t        acc
);

	localparam logic [12:0] BIT_LEN  = 13'((NUM_IRQS / 32) * 4);
	localparam logic [12:0] BYTE_LEN = 13'(NUM_IRQS);
	localparam logic [12:0] CFG_LEN  = 13'((NUM_IRQS / 16) * 4);

	logic [48:0] diff;
	logic [11:0] off;
	logic        bit_region;

	function automatic logic in_rng(logic [11:0] o, logic [11:0] s, logic [12:0] l);
		return ({1'b0, o} >= {1'b0, s}) && ({1'b0, o} < ({1'b0, s} + l));
	endfunction

	always_comb begin
		diff = {1'b0, req.address} - {1'b0, window_base};
		off  = diff[11:0];
		// A base above the address wraps into the top bit and fails the compare.
		acc.handled = diff < {36'b0, WINDOW_SIZE};
		acc.wr      = req.mode;
		acc.wdata   = req.write_data;
		bit_region  = 1'b0;

		if (off == OFF_CTLR) begin
			acc.sel = REG_CTLR;
		end else if (off == OFF_TYPER) begin
			acc.sel = REG_TYPER;
		end else if (off == OFF_IIDR) begin
			acc.sel = REG_IIDR;
		end else if (in_rng(off, OFF_GROUP, BIT_LEN)) begin
			acc.sel = REG_GROUP;
			bit_region = 1'b1;
		end else if (in_rng(off, OFF_SET_EN, BIT_LEN)) begin
			acc.sel = REG_SET_EN;
			bit_region = 1'b1;
		end else if (in_rng(off, OFF_CLR_EN, BIT_LEN)) begin
			acc.sel = REG_CLR_EN;
			bit_region = 1'b1;
		end else if (in_rng(off, OFF_SET_PEND, BIT_LEN)) begin
			acc.sel = REG_SET_PEND;
			bit_region = 1'b1;
		end else if (in_rng(off, OFF_CLR_PEND, BIT_LEN)) begin
			acc.sel = REG_CLR_PEND;
			bit_region = 1'b1;
		end else if (in_rng(off, OFF_PRIO, BYTE_LEN)) begin
			acc.sel = REG_PRIO;
		end else if (in_rng(off, OFF_TARGET, BYTE_LEN)) begin
			acc.sel = REG_TARGET;
		end else if (in_rng(off, OFF_CFG, CFG_LEN)) begin
			acc.sel = REG_CFG;
		end else begin
			acc.sel = REG_NONE;
		end

		// Bit regions start on 128-byte boundaries, the others on 1 KiB boundaries.
		acc.idx = bit_region ? {3'b000, off[6:2]} : off[9:2];
	end

endmodule

// ===== design/intd_regfile.sv =====
module intd_regfile import intd_pkg::*; #(
	parameter int NUM_IRQS = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  acc_t        acc,
	input  logic        apply,
	input  logic        pre_load,
	input  logic [7:0]  pre_idx,
	output logic [31:0] rdata
);

	localparam int BitWords  = NUM_IRQS / 32;
	localparam int ByteWords = (NUM_IRQS + 3) / 4;
	localparam int CfgWords  = NUM_IRQS / 16;
	localparam int BitW      = (BitWords > 1) ? $clog2(BitWords) : 1;
	localparam int MemW      = $clog2(ByteWords);
	localparam int CfgW      = $clog2(CfgWords);
	localparam logic [31:0] TYPER_VALUE = 32'(NUM_IRQS / 32 - 1);
	localparam logic [7:0]  BYTE_DEPTH  = 8'(ByteWords);

	logic              en_q;
	logic [31:0]       grp_q  [BitWords];
	logic [31:0]       ena_q  [BitWords];
	logic [31:0]       pend_q [BitWords];
	logic [31:0]       cfg_q  [CfgWords];
	logic [31:0]       pri_mem [ByteWords];
	logic [31:0]       tgt_mem [ByteWords];
	logic [ByteWords-1:0] pri_vld_q;
	logic [ByteWords-1:0] tgt_vld_q;
	logic [31:0]       pri_rd_q;
	logic [31:0]       tgt_rd_q;
	logic              pri_ok_q;
	logic              tgt_ok_q;

	logic              wr_go;
	logic              pri_wr;
	logic              tgt_wr;
	logic              pre_hit;
	logic              fwd;
	logic [BitW-1:0]   bi;
	logic [MemW-1:0]   mi;
	logic [MemW-1:0]   pmi;
	logic [CfgW-1:0]   ci;

	assign wr_go   = apply && acc.handled && acc.wr;
	assign pri_wr  = wr_go && (acc.sel == REG_PRIO);
	assign tgt_wr  = wr_go && (acc.sel == REG_TARGET) && (acc.idx >= TARGET_LOW_WORDS);
	assign pre_hit = pre_idx < BYTE_DEPTH;
	assign fwd     = acc.idx == pre_idx;
	assign bi      = acc.idx[BitW-1:0];
	assign mi      = acc.idx[MemW-1:0];
	assign pmi     = pre_idx[MemW-1:0];
	assign ci      = acc.idx[CfgW-1:0];

	// The word arrays are read with the incoming address as the access is accepted; a write
	// from the access ahead of it to the same word is forwarded into the read data.
	always_ff @(posedge clk) begin
		if (pri_wr) begin
			pri_mem[mi] <= acc.wdata;
		end
		if (tgt_wr) begin
			tgt_mem[mi] <= acc.wdata;
		end
		if (pre_load && pre_hit) begin
			pri_rd_q <= (pri_wr && fwd) ? acc.wdata : pri_mem[pmi];
			tgt_rd_q <= (tgt_wr && fwd) ? acc.wdata : tgt_mem[pmi];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			pri_vld_q <= '0;
			tgt_vld_q <= '0;
			pri_ok_q  <= 1'b0;
			tgt_ok_q  <= 1'b0;
			for (int i = 0; i < BitWords; i++) begin
				grp_q[i]  <= GROUP_RESET;
				ena_q[i]  <= '0;
				pend_q[i] <= '0;
			end
			for (int i = 0; i < CfgWords; i++) begin
				cfg_q[i] <= '0;
			end
		end else begin
			if (pre_load && pre_hit) begin
				pri_ok_q <= (pri_wr && fwd) || pri_vld_q[pmi];
				tgt_ok_q <= (tgt_wr && fwd) || tgt_vld_q[pmi];
			end
			if (pri_wr) begin
				pri_vld_q[mi] <= 1'b1;
			end
			if (tgt_wr) begin
				tgt_vld_q[mi] <= 1'b1;
			end
			if (wr_go) begin
				case (acc.sel)
					REG_CTLR:     en_q       <= acc.wdata[0];
					REG_GROUP:    grp_q[bi]  <= acc.wdata;
					REG_SET_EN:   ena_q[bi]  <= ena_q[bi] | acc.wdata;
					REG_CLR_EN:   ena_q[bi]  <= ena_q[bi] & ~acc.wdata;
					REG_SET_PEND: pend_q[bi] <= pend_q[bi] | acc.wdata;
					REG_CLR_PEND: pend_q[bi] <= pend_q[bi] & ~acc.wdata;
					REG_CFG:      cfg_q[ci]  <= acc.wdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (acc.sel)
			REG_CTLR:     rdata = {31'b0, en_q};
			REG_TYPER:    rdata = TYPER_VALUE;
			REG_IIDR:     rdata = IIDR_VALUE;
			REG_GROUP:    rdata = grp_q[bi];
			REG_SET_EN,
			REG_CLR_EN:   rdata = ena_q[bi];
			REG_SET_PEND,
			REG_CLR_PEND: rdata = pend_q[bi];
			REG_PRIO:     rdata = pri_ok_q ? pri_rd_q : PRIO_RESET;
			REG_TARGET: begin
				if (acc.idx < TARGET_LOW_WORDS) begin
					rdata = TARGET_LOW;
				end else begin
					rdata = tgt_ok_q ? tgt_rd_q : TARGET_RESET;
				end
			end
			REG_CFG:      rdata = cfg_q[ci];
			default:      rdata = '0;
		endcase
	end

endmodule

// ===== design/interrupt_distributor_registers.sv =====
// Register file of an emulated interrupt distributor.
// Request channel (req_valid, req_stall, req): one read or write word per
// access, taken at an edge where req_valid is high and req_stall is low.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one word per
// access, in order, with handled set when the address lies in the 4 KiB
// window and read_data holding the register value of a handled read.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): sets the window
// base; cfg_ready is always high. Change it only while no access is in flight.
// The access is registered at acceptance, then decoded and applied to the
// registers from that input stage, and its response word is held in the
// output register. Throughput is one access per cycle while no response is
// held; the priority and target arrays are read from the incoming address
// at acceptance so that decode and the register update need not wait on them.
// Reset empties both stages, sets the base to 0x08000000 and returns all
// registers to their reset values. While rsp_stall holds a response, one
// more access is still taken into the input stage; after that req_stall
// rises until the response is taken.
module interrupt_distributor_registers import intd_pkg::*; #(
	parameter int NUM_IRQS = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	logic [47:0] window_base_q;
	req_t        req_s1;
	logic        vld_s1;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic        adv;
	logic        req_fire;
	logic        s1_fire;
	logic [11:0] pre_off;
	acc_t        acc;
	logic [31:0] rd_word;

	assign cfg_ready = 1'b1;
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = vld_s1 && !adv;
	assign req_fire  = req_valid && !req_stall;
	assign s1_fire   = vld_s1 && adv;
	assign pre_off   = req.address[11:0] - window_base_q[11:0];
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	intd_decode #(
		.NUM_IRQS(NUM_IRQS)
	) u_decode (
		.req        (req_s1),
		.window_base(window_base_q),
		.acc        (acc)
	);

	intd_regfile #(
		.NUM_IRQS(NUM_IRQS)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.apply   (s1_fire),
		.pre_load(req_fire),
		.pre_idx (pre_off[9:2]),
		.rdata   (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= BASE_RESET;
			vld_s1        <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_base_q <= cfg_data;
			end
			if (!req_stall) begin
				vld_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1 <= req;
		end
		if (s1_fire) begin
			rsp_q.handled   <= acc.handled;
			rsp_q.read_data <= (acc.handled && !acc.wr) ? rd_word : '0;
		end
	end

endmodule

// ===== design/intd_checker.sv =====
module intd_port_checks import intd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// The input stage only backs up behind a response that is being held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("request stalled without a held response");

	// A response that appears after an empty cycle comes from an access that passed through the input stage.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("response word without a matching access");

	// Accesses outside the window never return data.
	a_unhandled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.handled) |-> (rsp.read_data == '0))
		else $error("unhandled access returned data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("held response word changed");

endmodule

bind interrupt_distributor_registers intd_port_checks u_port_checks (.*);

// ===== bench/intd_checker.sv =====
module intd_checker import intd_pkg::*; #(
	parameter int NUM_IRQS = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [47:0] cfg_data,
	input  logic        req_valid,
	input  logic        req_stall,
	input  req_t        req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  rsp_t        rsp,
	output int          errors,
	output int          in_flight
);

	localparam int BIT_WORDS  = NUM_IRQS / 32;
	localparam int BYTE_WORDS = (NUM_IRQS + 3) / 4;
	localparam int CFG_WORDS  = NUM_IRQS / 16;

	logic [47:0] base;
	logic        dist_en;
	logic [31:0] group_w   [BIT_WORDS];
	logic [31:0] enable_w  [BIT_WORDS];
	logic [31:0] pending_w [BIT_WORDS];
	logic [31:0] prio_w    [BYTE_WORDS];
	logic [31:0] target_w  [BYTE_WORDS];
	logic [31:0] trig_w    [CFG_WORDS];

	rsp_t        awaited_rsp [$];
	rsp_t        want_rsp;

	function automatic logic in_block(input logic [11:0] off, input logic [11:0] start,
			input int len);
		return (off >= start) && (int'(off) < int'(start) + len);
	endfunction

	// The low two address bits never select anything inside an array.
	function automatic int word_at(input logic [11:0] off, input logic [11:0] start);
		return (int'(off) - int'(start)) >> 2;
	endfunction

	// Applies one access to the register copy and returns the word it should produce.
	function automatic rsp_t access_regs(input req_t a);
		rsp_t        r;
		logic [48:0] top;
		logic [11:0] off;
		r = '0;
		top = {1'b0, base} + 49'(WINDOW_SIZE);
		if ({1'b0, a.address} < {1'b0, base} || {1'b0, a.address} >= top)
			return r;
		off = 12'(a.address - base);
		r.handled = 1'b1;
		if (!a.mode) begin
			if (off == OFF_CTLR)
				r.read_data = {31'b0, dist_en};
			else if (off == OFF_TYPER)
				r.read_data = 32'(NUM_IRQS / 32 - 1);
			else if (off == OFF_IIDR)
				r.read_data = IIDR_VALUE;
			else if (in_block(off, OFF_GROUP, 4 * BIT_WORDS))
				r.read_data = group_w[word_at(off, OFF_GROUP)];
			else if (in_block(off, OFF_SET_EN, 4 * BIT_WORDS))
				r.read_data = enable_w[word_at(off, OFF_SET_EN)];
			else if (in_block(off, OFF_CLR_EN, 4 * BIT_WORDS))
				r.read_data = enable_w[word_at(off, OFF_CLR_EN)];
			else if (in_block(off, OFF_SET_PEND, 4 * BIT_WORDS))
				r.read_data = pending_w[word_at(off, OFF_SET_PEND)];
			else if (in_block(off, OFF_CLR_PEND, 4 * BIT_WORDS))
				r.read_data = pending_w[word_at(off, OFF_CLR_PEND)];
			else if (in_block(off, OFF_PRIO, NUM_IRQS))
				r.read_data = prio_w[word_at(off, OFF_PRIO)];
			else if (in_block(off, OFF_TARGET, NUM_IRQS)) begin
				if (word_at(off, OFF_TARGET) < int'(TARGET_LOW_WORDS))
					r.read_data = TARGET_LOW;
				else
					r.read_data = target_w[word_at(off, OFF_TARGET)];
			end else if (in_block(off, OFF_CFG, 4 * CFG_WORDS))
				r.read_data = trig_w[word_at(off, OFF_CFG)];
		end else begin
			if (off == OFF_CTLR)
				dist_en = a.write_data[0];
			else if (in_block(off, OFF_GROUP, 4 * BIT_WORDS))
				group_w[word_at(off, OFF_GROUP)] = a.write_data;
			else if (in_block(off, OFF_SET_EN, 4 * BIT_WORDS))
				enable_w[word_at(off, OFF_SET_EN)] |= a.write_data;
			else if (in_block(off, OFF_CLR_EN, 4 * BIT_WORDS))
				enable_w[word_at(off, OFF_CLR_EN)] &= ~a.write_data;
			else if (in_block(off, OFF_SET_PEND, 4 * BIT_WORDS))
				pending_w[word_at(off, OFF_SET_PEND)] |= a.write_data;
			else if (in_block(off, OFF_CLR_PEND, 4 * BIT_WORDS))
				pending_w[word_at(off, OFF_CLR_PEND)] &= ~a.write_data;
			else if (in_block(off, OFF_PRIO, NUM_IRQS))
				prio_w[word_at(off, OFF_PRIO)] = a.write_data;
			else if (in_block(off, OFF_TARGET, NUM_IRQS)) begin
				if (word_at(off, OFF_TARGET) >= int'(TARGET_LOW_WORDS))
					target_w[word_at(off, OFF_TARGET)] = a.write_data;
			end else if (in_block(off, OFF_CFG, 4 * CFG_WORDS))
				trig_w[word_at(off, OFF_CFG)] = a.write_data;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base = BASE_RESET;
			dist_en = 1'b0;
			for (int i = 0; i < BIT_WORDS; i++) begin
				group_w[i] = GROUP_RESET;
				enable_w[i] = '0;
				pending_w[i] = '0;
			end
			for (int i = 0; i < BYTE_WORDS; i++) begin
				prio_w[i] = PRIO_RESET;
				target_w[i] = TARGET_RESET;
			end
			for (int i = 0; i < CFG_WORDS; i++)
				trig_w[i] = '0;
			awaited_rsp.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				base = cfg_data;
			// Compare before pushing, so a response word can never be matched
			// against the access taken at the same edge.
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: response word %h arrived with none expected", $time, rsp);
				end else begin
					want_rsp = awaited_rsp.pop_front();
					if (rsp.handled !== want_rsp.handled) begin
						errors++;
						$display("%0t: handled expected %0b actual %0b", $time,
							want_rsp.handled, rsp.handled);
					end
					if (rsp.read_data !== want_rsp.read_data) begin
						errors++;
						$display("%0t: read_data expected %h actual %h", $time,
							want_rsp.read_data, rsp.read_data);
					end
				end
			end
			if (req_valid && !req_stall)
				awaited_rsp.push_back(access_regs(req));
		end
		in_flight = awaited_rsp.size();
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	import intd_pkg::*;

	localparam int          NUM_IRQS   = 96;
	localparam logic        MODE_READ  = 1'b0;
	localparam logic        MODE_WRITE = 1'b1;
	localparam logic [47:0] ADDR_MAX   = 48'hFFFF_FFFF_FFFF;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [47:0] cfg_data  = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	int          errors;
	int          in_flight;
	int          gap_pct   = 0;
	int          stall_pct = 0;
	logic [47:0] cur_base  = BASE_RESET;

	interrupt_distributor_registers #(.NUM_IRQS(NUM_IRQS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	intd_checker #(.NUM_IRQS(NUM_IRQS)) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.in_flight (in_flight)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("interrupt_distributor_registers verification failed");
		$finish;
	end

	always @(posedge clk) begin
		rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic logic [47:0] reg_addr(input logic [11:0] off);
		return cur_base + 48'(off);
	endfunction

	// Mostly offsets near real registers, including unaligned ones and the
	// first few bytes past the end of each array.
	function automatic logic [11:0] pick_offset();
		case ($urandom_range(11))
			0: return 12'($urandom_range(2) * 4) | 12'(($urandom_range(3) == 0) ? $urandom_range(3) : 0);
			1: return OFF_GROUP + 12'($urandom_range(4 * (NUM_IRQS / 32) + 3));
			2: return OFF_SET_EN + 12'($urandom_range(4 * (NUM_IRQS / 32) + 3));
			3: return OFF_CLR_EN + 12'($urandom_range(4 * (NUM_IRQS / 32) + 3));
			4: return OFF_SET_PEND + 12'($urandom_range(4 * (NUM_IRQS / 32) + 3));
			5: return OFF_CLR_PEND + 12'($urandom_range(4 * (NUM_IRQS / 32) + 3));
			6, 7: return OFF_PRIO + 12'($urandom_range(NUM_IRQS + 3));
			8: return OFF_TARGET + 12'($urandom_range(4 * int'(TARGET_LOW_WORDS) - 1));
			9: return OFF_TARGET + 12'($urandom_range(NUM_IRQS + 3));
			10: return OFF_CFG + 12'($urandom_range(4 * (NUM_IRQS / 16) + 3));
			default: return 12'($urandom_range(12'hFFF));
		endcase
	endfunction

	function automatic logic [47:0] pick_address();
		int k;
		k = $urandom_range(99);
		if (k < 82)
			return reg_addr(pick_offset());
		if (k < 90)
			return 48'({$urandom, $urandom});
		case ($urandom_range(4))
			0: return cur_base - 48'd1;
			1: return cur_base + 48'h0FFF;
			2: return cur_base + 48'(WINDOW_SIZE);
			3: return '0;
			default: return ADDR_MAX;
		endcase
	endfunction

	function automatic logic [31:0] pick_data();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Valid stays high straight into the next word when there is no gap.
	task automatic issue(input logic mode, input logic [47:0] addr, input logic [31:0] data);
		req_t a;
		a.mode = mode;
		a.address = addr;
		a.write_data = data;
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= a;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic set_base(input logic [47:0] b);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_base = b;
	endtask

	initial begin
		logic [47:0] bases [6];
		bases[0] = '0;
		bases[1] = ADDR_MAX;
		bases[2] = ADDR_MAX - 48'h0FFF;
		bases[3] = 48'({$urandom, $urandom}) & ~48'h0FFF;
		bases[4] = 48'({$urandom, $urandom});
		bases[5] = BASE_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(MODE_READ, reg_addr(OFF_CTLR), '1);
		issue(MODE_READ, reg_addr(OFF_TYPER), '0);
		issue(MODE_READ, reg_addr(OFF_IIDR), '0);
		issue(MODE_WRITE, reg_addr(OFF_CTLR), '1);
		issue(MODE_READ, reg_addr(OFF_CTLR), '0);
		// The single registers only answer at their exact offset.
		issue(MODE_READ, reg_addr(OFF_CTLR + 12'd1), '0);
		issue(MODE_WRITE, reg_addr(OFF_SET_EN + 12'd4), 32'hF0F0_F0F0);
		issue(MODE_WRITE, reg_addr(OFF_CLR_EN + 12'd5), 32'h3030_3030);
		issue(MODE_READ, reg_addr(OFF_CLR_EN + 12'd4), '0);
		issue(MODE_WRITE, reg_addr(OFF_SET_PEND + 12'd8), '1);
		issue(MODE_WRITE, reg_addr(OFF_CLR_PEND + 12'd8), 32'h0000_FFFF);
		issue(MODE_READ, reg_addr(OFF_SET_PEND + 12'd9), '0);
		issue(MODE_WRITE, reg_addr(OFF_GROUP), '0);
		issue(MODE_READ, reg_addr(OFF_GROUP + 12'd3), '0);
		// A byte write to a priority acts on the whole word.
		issue(MODE_WRITE, reg_addr(OFF_PRIO + 12'd3), 32'h1234_5678);
		issue(MODE_READ, reg_addr(OFF_PRIO), '0);
		issue(MODE_WRITE, reg_addr(OFF_TARGET + 12'h1C), '0);
		issue(MODE_READ, reg_addr(OFF_TARGET + 12'h1F), '0);
		issue(MODE_WRITE, reg_addr(OFF_TARGET + 12'h20), 32'hDEAD_BEEF);
		issue(MODE_READ, reg_addr(OFF_TARGET + 12'h22), '0);
		issue(MODE_WRITE, reg_addr(OFF_CFG + 12'h14), '1);
		issue(MODE_READ, reg_addr(OFF_CFG + 12'h17), '0);
		issue(MODE_READ, reg_addr(12'h300), '0);
		issue(MODE_READ, reg_addr(OFF_CFG + 12'h18), '0);
		issue(MODE_READ, cur_base - 48'd1, '0);
		issue(MODE_WRITE, cur_base + 48'(WINDOW_SIZE), '1);

		for (int p = 0; p <= 6; p++) begin
			if (p > 0)
				set_base(bases[p - 1]);
			for (int m = 0; m < 4; m++) begin
				case (m)
					0: begin
						gap_pct = 0;
						stall_pct = 0;
					end
					1: begin
						gap_pct = 85;
						stall_pct = 0;
					end
					2: begin
						gap_pct = 0;
						stall_pct = 85;
					end
					default: begin
						gap_pct = 10;
						stall_pct = 10;
					end
				endcase
				repeat (55)
					issue(logic'($urandom_range(1)), pick_address(), pick_data());
			end
		end

		req_valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 10000 && in_flight != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0 && in_flight == 0)
			$display("interrupt_distributor_registers verification clean");
		else
			$display("interrupt_distributor_registers verification failed");
		$finish;
	end

endmodule
